FILE: design/rrs_pkg.sv
// Shared types, codes and field widths for the rank roulette selection core.
`timescale 1ns / 1ps

package rrs_pkg;

    localparam int RANK_W    = 7;
    localparam int SEL_W     = 7;
    localparam int ENTRY_W   = 7;
    localparam int FRAC_W    = 16;
    localparam int POP_W     = 8;
    localparam int FDIF_W    = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    // Running sum in Q8, compared after a shift by 8; covers populations up to 1024.
    localparam int ACC_W     = 48;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POP_SIZE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_PRESSURE = 1'b1;

    localparam logic [POP_W-1:0]  POP_SIZE_RESET      = 8'd100;
    localparam logic [FDIF_W-1:0] RANK_PRESSURE_RESET = 9'd256;

    typedef struct packed {
        logic               command;
        logic [ENTRY_W-1:0] entry_index;
        logic [RANK_W-1:0]  rank_value;
        logic [FRAC_W-1:0]  random_fraction;
    } in_word_t;

    typedef struct packed {
        logic [SEL_W-1:0] selected_index;
        logic             found;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_WALK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic write_entry;
        logic start;
        logic mul1;
        logic mul2;
        logic issue;
        logic capture;
        logic load_out;
    } rrs_cmd_t;

    typedef struct packed {
        logic more;
        logic np_zero;
        logic hit;
        logic last;
        logic out_free;
    } rrs_status_t;

endpackage

FILE: design/rrs_ctrl.sv
// Controller state machine for the rank roulette selection core.
`timescale 1ns / 1ps

module rrs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_command,
    output logic                 in_stall,
    output rrs_pkg::rrs_cmd_t    cmd,
    input  rrs_pkg::rrs_status_t st
);
    import rrs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_command == CMD_SELECT)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        cmd.write_entry = 1'b1;
                    end
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.issue = st.more;
                if (st.np_zero || st.hit || st.last)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A hit during the walk must end it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && st.hit) |=> (state_reg == S_DONE))
        else $error("walk continued past a hit");

    // A select word always starts with the threshold multiply.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == S_MUL1))
        else $error("select did not enter setup");
`endif

endmodule

FILE: design/rrs_datapath.sv
// Datapath: rank table, threshold multiplies, walk pipeline and output register.
`timescale 1ns / 1ps

module rrs_datapath #(
    parameter int MAX_POP = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [rrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rrs_pkg::CFG_W-1:0]     cfg_data,
    input  rrs_pkg::in_word_t             in_word,
    input  rrs_pkg::rrs_cmd_t             cmd,
    output rrs_pkg::rrs_status_t          st,
    input  logic                          out_stall,
    output logic                          out_valid,
    output rrs_pkg::out_word_t            out_word
);
    import rrs_pkg::*;

    localparam int IDX_W = $clog2(MAX_POP);
    localparam int NP_W  = $clog2(MAX_POP + 1);
    localparam int K_W   = ((NP_W > RANK_W + 1) ? NP_W : RANK_W + 1) + 1;
    localparam int T_W   = K_W + FDIF_W + 2;
    localparam int P1_W  = FRAC_W + NP_W;
    localparam int TH_W  = FRAC_W + 2 * NP_W + 1;

    // configuration
    logic [POP_W-1:0]  pop_size_reg;
    logic [FDIF_W-1:0] rank_pressure_reg;

    // per-select setup
    logic [NP_W-1:0]   np_c;
    logic [NP_W-1:0]   np_reg;
    logic [NP_W:0]     np_p1_reg;
    logic [NP_W-1:0]   npm1_reg;
    logic [FDIF_W-1:0] fdif_reg;
    logic [FRAC_W-1:0] u_reg;
    logic [P1_W-1:0]   prod1_reg;
    logic [TH_W-1:0]   thresh_reg;

    // rank table
    logic [RANK_W-1:0] mem [MAX_POP];
    logic [RANK_W-1:0] rdata_reg;
    logic              wr_ok;

    // walk pipeline: read, rank term, weighted term, running sum
    logic [NP_W-1:0]         addr_reg;
    logic                    vm_reg, va_reg, vb_reg, vc_reg;
    logic [IDX_W-1:0]        idxm_reg, idxa_reg, idxb_reg, idxc_reg;
    logic signed [K_W-1:0]   k_next, k_reg;
    logic signed [FDIF_W:0]  fdif_s;
    logic signed [FDIF_W+K_W:0] prod;
    logic signed [NP_W+9:0]  base_s;
    logic signed [T_W-1:0]   term_next, term_reg;
    logic signed [ACC_W-1:0] sum_reg;
    logic signed [ACC_W-1:0] thr_s;
    logic                    ge;

    // result
    out_word_t res_reg;
    out_word_t out_word_reg;
    logic      out_valid_reg;

    assign np_c  = (int'(pop_size_reg) > MAX_POP) ? NP_W'(MAX_POP) : NP_W'(pop_size_reg);
    assign wr_ok = int'(in_word.entry_index) < MAX_POP;

    assign k_next    = $signed(K_W'(npm1_reg)) - $signed(K_W'({rdata_reg, 1'b0}));
    assign fdif_s    = $signed({1'b0, fdif_reg});
    assign prod      = fdif_s * k_reg;
    assign base_s    = $signed({1'b0, np_p1_reg, 8'b0});
    assign term_next = T_W'(prod) + T_W'(base_s);
    assign thr_s     = $signed(ACC_W'(thresh_reg));
    assign ge        = (sum_reg <<< 8) >= thr_s;

    assign st.more     = addr_reg < np_reg;
    assign st.np_zero  = (np_reg == '0);
    assign st.hit      = vc_reg && ge;
    assign st.last     = vc_reg && (NP_W'(idxc_reg) == npm1_reg);
    assign st.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_size_reg      <= POP_SIZE_RESET;
            rank_pressure_reg <= RANK_PRESSURE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_POP_SIZE:      pop_size_reg      <= cfg_data[POP_W-1:0];
                CFG_RANK_PRESSURE: rank_pressure_reg <= cfg_data[FDIF_W-1:0];
                default:           pop_size_reg      <= pop_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && wr_ok)
        begin
            mem[IDX_W'(in_word.entry_index)] <= in_word.rank_value;
        end
        rdata_reg <= mem[addr_reg[IDX_W-1:0]];
    end

    // setup registers and pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            np_reg    <= np_c;
            np_p1_reg <= {1'b0, np_c} + (NP_W + 1)'(1);
            npm1_reg  <= np_c - NP_W'(1);
            fdif_reg  <= rank_pressure_reg;
            u_reg     <= in_word.random_fraction;
        end
        if (cmd.mul1)
        begin
            prod1_reg <= u_reg * np_reg;
        end
        if (cmd.mul2)
        begin
            thresh_reg <= prod1_reg * np_p1_reg;
        end
        idxm_reg <= addr_reg[IDX_W-1:0];
        idxa_reg <= idxm_reg;
        idxb_reg <= idxa_reg;
        idxc_reg <= idxb_reg;
        k_reg    <= k_next;
        term_reg <= term_next;
        if (cmd.capture)
        begin
            res_reg.found          <= st.hit;
            res_reg.selected_index <= st.hit ? SEL_W'(idxc_reg) : '0;
        end
        if (cmd.load_out)
        begin
            out_word_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            vm_reg        <= 1'b0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                addr_reg <= '0;
                vm_reg   <= 1'b0;
                va_reg   <= 1'b0;
                vb_reg   <= 1'b0;
                vc_reg   <= 1'b0;
                sum_reg  <= '0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    addr_reg <= addr_reg + NP_W'(1);
                end
                vm_reg <= cmd.issue;
                va_reg <= vm_reg;
                vb_reg <= va_reg;
                vc_reg <= vb_reg;
                if (vb_reg)
                begin
                    sum_reg <= sum_reg + ACC_W'(term_reg);
                end
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // The walk never carries an entry beyond the population in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg |-> (NP_W'(idxc_reg) < np_reg))
        else $error("walk entry beyond population");

    // A pending result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> st.out_free)
        else $error("output word overwritten");

    // Output valid rises only from a load.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load_out))
        else $error("output valid without load");
`endif

endmodule

FILE: design/rank_roulette_selection_core.sv
// Top level of the rank-based roulette wheel selection core.
`timescale 1ns / 1ps

// Input channel (in_valid / in_stall / in_word) takes two kinds of word.
// A write word stores rank_value at entry_index in the rank table; it is
// taken while the core is idle and gives no result. A select word walks
// the table from entry 0 and returns one output word: the first index
// whose running rank-weighted sum reaches random_fraction of the total, or
// found = 0. It runs two threshold multiplies, then one table read per
// cycle down a four-stage read / term / accumulate pipeline, captures the
// result and loads it into the output register, which raises out_valid.
// in_stall is high while a select is in progress; the next word is taken
// once the result has been loaded, which waits until the output register
// is free. The output word sits in a register; if out_stall holds it, the
// next select still runs and waits at its end until the register frees.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and must be made only while the core is idle; the core does not enforce
// this. Reset sets pop_size to 100 and rank pressure to 1.0 and clears
// control state; the rank table holds no defined value until written.

module rank_roulette_selection_core #(
    parameter int MAX_POP = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [rrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rrs_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  rrs_pkg::in_word_t             in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output rrs_pkg::out_word_t            out_word
);
    import rrs_pkg::*;

    rrs_cmd_t    cmd;
    rrs_status_t st;

    rrs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_word.command),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .st         (st)
    );

    rrs_datapath #(
        .MAX_POP (MAX_POP)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .st        (st),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the rank roulette selection core.
`timescale 1ns / 1ps

module tb;
    import rrs_pkg::*;

    localparam int POP_CAP = 128;
    // Long enough to cover the longest select, with margin on top of that.
    localparam int HOLD_CYCLES = POP_CAP + 24;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_word_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_word_t out_word;

    rank_roulette_selection_core #(
        .MAX_POP(POP_CAP)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word(out_word)
    );

    // Mirror of the core's table and registers
    logic [RANK_W-1:0] rank_mirror [POP_CAP];
    logic [POP_W-1:0] pop_mirror = POP_SIZE_RESET;
    logic [FDIF_W-1:0] pressure_mirror = RANK_PRESSURE_RESET;

    out_word_t pending_picks[$];
    out_word_t want;
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #(64'd10_000_000);
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Walk the mirrored table the way the core does and return its pick.
    function automatic out_word_t pick_member(input logic [FRAC_W-1:0] frac);
        longint np;
        longint fdif;
        longint acc;
        longint goal;
        longint r;
        longint uq;
        bit done;
        out_word_t res;
        np = pop_mirror;
        if (np > POP_CAP)
            np = POP_CAP;
        fdif = pressure_mirror;
        uq = frac;
        goal = uq * np * (np + 1);
        acc = 0;
        done = 1'b0;
        res = '0;
        for (int i = 0; i < np && !done; i++)
        begin
            r = rank_mirror[i];
            acc += 256 * (np + 1) + fdif * (np - 1 - 2 * r);
            if (acc * 256 >= goal)
            begin
                res.selected_index = i[SEL_W-1:0];
                res.found = 1'b1;
                done = 1'b1;
            end
        end
        return res;
    endfunction

    // Result side: random stall, compare each accepted word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_picks.size() == 0)
                report_mismatch($sformatf("unexpected result index %0d found %0b",
                                          out_word.selected_index, out_word.found));
            else
            begin
                want = pending_picks.pop_front();
                if (out_word.selected_index !== want.selected_index)
                    report_mismatch($sformatf("selected_index got %0d want %0d",
                                              out_word.selected_index, want.selected_index));
                if (out_word.found !== want.found)
                    report_mismatch($sformatf("found got %0b want %0b (index %0d)",
                                              out_word.found, want.found,
                                              want.selected_index));
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Called right after a rising edge; returns at the edge that took the word.
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (w.command == CMD_WRITE)
            rank_mirror[w.entry_index] = w.rank_value;
        else
            pending_picks.push_back(pick_member(w.random_fraction));
    endtask

    task automatic write_entry(input int idx, input int rank);
        in_word_t w;
        w.command = CMD_WRITE;
        w.entry_index = idx[ENTRY_W-1:0];
        w.rank_value = rank[RANK_W-1:0];
        w.random_fraction = FRAC_W'($urandom());
        send_word(w);
    endtask

    task automatic select_at(input int frac);
        in_word_t w;
        w.command = CMD_SELECT;
        w.entry_index = ENTRY_W'($urandom());
        w.rank_value = RANK_W'($urandom());
        w.random_fraction = frac[FRAC_W-1:0];
        send_word(w);
    endtask

    // Stop sending, wait for every pending result, then let the core go quiet.
    task automatic settle(input int hold);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (hold) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_POP_SIZE)
            pop_mirror = value[POP_W-1:0];
        else
            pressure_mirror = value[FDIF_W-1:0];
        @(posedge clk);
    endtask

    task automatic reconfigure(input int pop, input int pressure);
        settle(HOLD_CYCLES);
        set_reg(CFG_POP_SIZE, pop);
        set_reg(CFG_RANK_PRESSURE, pressure);
    endtask

    // Every entry gets a rank before anything reads the table.
    task automatic test_table_fill();
        for (int i = 0; i < POP_CAP; i++)
            write_entry(i, (i * 37 + 11) % POP_CAP);
    endtask

    task automatic test_directed();
        // reset settings
        select_at(0);
        select_at(16'hFFFF);
        select_at(16'h8000);
        write_entry(0, 127);
        write_entry(127, 0);
        select_at(16'hFFFF);
        // empty population never finds
        reconfigure(0, 256);
        select_at(0);
        // single member
        reconfigure(1, 256);
        select_at(0);
        select_at(16'hFFFF);
        // two worst-ranked members give negative terms: not found
        reconfigure(2, 256);
        write_entry(1, 127);
        select_at(1);
        select_at(0);
        // no pressure: flat wheel, last member just reaches the top
        reconfigure(2, 0);
        select_at(16'hFFFF);
        // above capacity saturates to the table size
        reconfigure(255, 256);
        select_at(16'hFFFF);
        select_at(12345);
        reconfigure(128, 256);
        select_at(16'hFFFF);
        select_at(0);
        // top data bit lies outside the population register
        reconfigure(9'h180, 9'h1FF);
        select_at(40000);
        select_at(16'hFFFF);
    endtask

    task automatic random_settings();
        int pop;
        int pressure;
        case ($urandom_range(5))
            0: pop = 2;
            1: pop = 128;
            2: pop = $urandom_range(16, 2);
            3: pop = $urandom_range(128, 2);
            4: pop = $urandom_range(255, 129);
            default: pop = $urandom_range(1, 0);
        endcase
        case ($urandom_range(3))
            0: pressure = 0;
            1: pressure = 256;
            2: pressure = $urandom_range(256, 0);
            default: pressure = $urandom_range(511, 257);
        endcase
        reconfigure(pop, pressure);
    endtask

    task automatic run_random_phase(input int idle, input int stall, input int count);
        in_word_t w;
        int span;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int half = 0; half < 2; half++)
        begin
            random_settings();
            span = (pop_mirror > POP_CAP) ? POP_CAP : pop_mirror;
            if (span < 1)
                span = 1;
            for (int n = 0; n < count / 2; n++)
            begin
                w.command = ($urandom_range(99) < 55) ? CMD_SELECT : CMD_WRITE;
                w.entry_index = ($urandom_range(3) == 0) ? ENTRY_W'($urandom())
                                                         : ENTRY_W'($urandom_range(span - 1));
                // mostly ranks that fit the population, sometimes any rank
                w.rank_value = ($urandom_range(3) == 0) ? RANK_W'($urandom())
                                                        : RANK_W'($urandom_range(span - 1));
                case ($urandom_range(15))
                    0: w.random_fraction = '0;
                    1: w.random_fraction = '1;
                    default: w.random_fraction = FRAC_W'($urandom());
                endcase
                send_word(w);
                if ($urandom_range(49) == 0)
                    settle(0);
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_fill();
        test_directed();
        run_random_phase(0, 0, 250);
        run_random_phase(72, 0, 250);
        run_random_phase(0, 72, 250);
        run_random_phase(19, 19, 250);
        settle(HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
